>>> hdl/gfla_pkg.sv
// ----------------------------------------------------------------------------
// gfla_pkg
// Shared types and constants for the log-domain finite field ALU.
// ----------------------------------------------------------------------------
package gfla_pkg;

  localparam int unsigned DEFAULT_ELEM_BITS = 8;

  // operation codes carried in the kind field
  localparam int unsigned KIND_W = 3;
  typedef enum logic [KIND_W-1:0] {
    KIND_ADD  = 3'd0,
    KIND_SUB  = 3'd1,
    KIND_MUL  = 3'd2,
    KIND_DIV  = 3'd3,
    KIND_NEG  = 3'd4,
    KIND_INV  = 3'd5,
    KIND_LOAD = 3'd6
  } kind_t;

  // configuration port
  localparam int unsigned APB_ADDR_W    = 3;
  localparam int unsigned APB_DATA_W    = 32;
  localparam int unsigned FIELD_SIZE_W  = 9;
  localparam logic [FIELD_SIZE_W-1:0] FIELD_SIZE_RESET = 9'd256;
  localparam int unsigned FIELD_SIZE_MIN = 2;

  // register index, taken from paddr[2]
  typedef enum logic [0:0] {
    REG_FIELD_SIZE = 1'b0,
    REG_ODD_CHAR   = 1'b1
  } reg_idx_t;

  // remainder bits retired per pipeline stage
  localparam int unsigned REDUCE_STEPS = 4;

endpackage

>>> hdl/gfla_op_if.sv
// ----------------------------------------------------------------------------
// gfla_op_if
// Operation channel: valid/ready handshake with one operation item.
// ----------------------------------------------------------------------------
interface gfla_op_if
  import gfla_pkg::*;
#(
  parameter int unsigned ELEM_BITS = DEFAULT_ELEM_BITS
) ();
  logic                 valid;
  logic                 ready;
  logic [KIND_W-1:0]    kind;
  logic [ELEM_BITS-1:0] operand_a;
  logic [ELEM_BITS-1:0] operand_b;
  logic [ELEM_BITS-1:0] table_index;
  logic [ELEM_BITS-1:0] table_entry;

  modport source (
    output valid, kind, operand_a, operand_b, table_index, table_entry,
    input  ready
  );
  modport sink (
    input  valid, kind, operand_a, operand_b, table_index, table_entry,
    output ready
  );
endinterface

>>> hdl/gfla_res_if.sv
// ----------------------------------------------------------------------------
// gfla_res_if
// Result channel: valid/ready handshake with one result item.
// ----------------------------------------------------------------------------
interface gfla_res_if
  import gfla_pkg::*;
#(
  parameter int unsigned ELEM_BITS = DEFAULT_ELEM_BITS
) ();
  logic                 valid;
  logic                 ready;
  logic [ELEM_BITS-1:0] result_value;
  logic                 error_flag;

  modport source (
    output valid, result_value, error_flag,
    input  ready
  );
  modport sink (
    input  valid, result_value, error_flag,
    output ready
  );
endinterface

>>> hdl/gf_log_domain_alu.sv
// ----------------------------------------------------------------------------
// gf_log_domain_alu
// GF(q) arithmetic on log-coded elements (0 = zero, i = alpha^(i-1)).
// Items arrive on op (add, sub, mul, div, neg, inverse, Zech table load) and
// each gives exactly one item on res. Config (field size q, odd
// characteristic) is written over APB at 0x0 and 0x4; the user must write
// it only while the unit is idle, as the block itself does not enforce this.
// The two remainder pipelines retire four quotient bits per stage.
// Throughput: one item per cycle while res is not stalled.
// A Zech load writes the table as it leaves P1, the stage whose address the
// adds read, so every item sees exactly the loads accepted before it.
// When res stalls the whole pipeline holds and op.ready drops; the output
// register keeps its item until taken. Reset clears all valid bits and sets
// q = 256, characteristic two; the Zech table is not cleared and must be
// loaded before any add or subtract reads it.
// ----------------------------------------------------------------------------
module gf_log_domain_alu
  import gfla_pkg::*;
#(
  parameter int unsigned ELEM_BITS = DEFAULT_ELEM_BITS
) (
  input  logic                  clk,
  input  logic                  rst,
  // APB config port
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [APB_ADDR_W-1:0] paddr,
  input  logic [APB_DATA_W-1:0] pwdata,
  output logic [APB_DATA_W-1:0] prdata,
  output logic                  pready,
  // item channels
  gfla_op_if.sink               op,
  gfla_res_if.source            res
);

  localparam int unsigned EB    = ELEM_BITS;
  localparam int unsigned QW    = EB + 1;
  localparam int unsigned CW    = (EB + 1 > FIELD_SIZE_W) ? EB + 1 : FIELD_SIZE_W;
  localparam int unsigned DEPTH = 1 << EB;
  localparam int unsigned K     = REDUCE_STEPS;
  // stages for operand reduction mod q and for the Zech sum mod (q-1)
  localparam int unsigned NA    = (EB + K - 1) / K;
  localparam int unsigned NS    = (EB + 1 + K - 1) / K;
  localparam int unsigned PADA  = NA * K;
  localparam int unsigned PADS  = NS * K;

  // --------------------------------------------------------------------------
  // Field arithmetic helpers
  // --------------------------------------------------------------------------

  // K steps of restoring long division, remainder only; r < d on entry
  function automatic logic [EB-1:0] rem_step(input logic [EB-1:0] r,
                                             input logic [K-1:0]  bits,
                                             input logic [EB:0]   d);
    logic [EB:0]   t;
    logic [EB-1:0] acc;
    acc = r;
    for (int i = K - 1; i >= 0; i--) begin
      t = {acc, bits[i]};
      if (t >= d) t = t - d;
      acc = t[EB-1:0];
    end
    return acc;
  endfunction

  // negation: half-period rotation in odd characteristic
  function automatic logic [EB-1:0] gf_neg(input logic [EB-1:0] x,
                                           input logic [EB-1:0] nn,
                                           input logic [EB-1:0] hh,
                                           input logic          oddc);
    logic [EB:0] t;
    t = (EB+1)'(x) + (EB+1)'(hh) - (EB+1)'(1);
    if (t >= (EB+1)'(nn)) t = t - (EB+1)'(nn);
    if (x == '0 || !oddc) return x;
    return EB'(t + (EB+1)'(1));
  endfunction

  function automatic logic [EB-1:0] gf_mul(input logic [EB-1:0] x,
                                           input logic [EB-1:0] y,
                                           input logic [EB-1:0] nn);
    logic [EB:0] t;
    t = (EB+1)'(x) + (EB+1)'(y) - (EB+1)'(2);
    if (t >= (EB+1)'(nn)) t = t - (EB+1)'(nn);
    if (x == '0 || y == '0) return '0;
    return EB'(t + (EB+1)'(1));
  endfunction

  // inverse of a nonzero element; zero is flagged elsewhere
  function automatic logic [EB-1:0] gf_inv(input logic [EB-1:0] x,
                                           input logic [QW-1:0] qq);
    if (x == EB'(1)) return EB'(1);
    return EB'(qq + QW'(1) - QW'(x));
  endfunction

  // --------------------------------------------------------------------------
  // Configuration registers
  // --------------------------------------------------------------------------
  logic [FIELD_SIZE_W-1:0] field_size;
  logic                    odd_characteristic;
  logic                    cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      field_size         <= FIELD_SIZE_RESET;
      odd_characteristic <= 1'b0;
    end else if (cfg_wr) begin
      unique case (reg_idx_t'(paddr[2]))
        REG_FIELD_SIZE: field_size         <= pwdata[FIELD_SIZE_W-1:0];
        REG_ODD_CHAR:   odd_characteristic <= pwdata[0];
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx_t'(paddr[2]))
      REG_FIELD_SIZE: prdata = APB_DATA_W'(field_size);
      REG_ODD_CHAR:   prdata = APB_DATA_W'(odd_characteristic);
    endcase
  end

  // Effective q, clamped to [2, 2^E]; n = q-1; half-period for negation.
  // Config must be changed only while idle (not enforced): kept combinational.
  logic [CW-1:0] fs_ext;
  logic [CW-1:0] q_c;
  logic [QW-1:0] q;
  logic [EB-1:0] n;
  logic [EB-1:0] half;

  always_comb begin
    fs_ext = CW'(field_size);
    if (fs_ext < CW'(FIELD_SIZE_MIN))  q_c = CW'(FIELD_SIZE_MIN);
    else if (fs_ext > CW'(DEPTH))      q_c = CW'(DEPTH);
    else                               q_c = fs_ext;
    q    = QW'(q_c);
    n    = EB'(q - QW'(1));
    half = odd_characteristic ? (n >> 1) : '0;
  end

  // --------------------------------------------------------------------------
  // Pipeline control: a single advance for all stages. While a result waits
  // in the output register everything holds and op.ready drops with it.
  // --------------------------------------------------------------------------
  logic adv;

  assign adv      = !res.valid || res.ready;
  assign op.ready = adv;

  // --------------------------------------------------------------------------
  // Stages R0..R(NA-1): operands reduced mod q, K bits per stage
  // --------------------------------------------------------------------------
  logic [EB-1:0]   ra_r   [NA];
  logic [EB-1:0]   rb_r   [NA];
  logic [PADA-1:0] ra_v   [NA];
  logic [PADA-1:0] rb_v   [NA];
  logic [EB-1:0]   rti    [NA];
  logic [EB-1:0]   rte    [NA];
  kind_t           rk     [NA];
  logic            rvalid [NA];

  logic [EB-1:0]   ra_src [NA];
  logic [EB-1:0]   rb_src [NA];
  logic [PADA-1:0] rav_src[NA];
  logic [PADA-1:0] rbv_src[NA];
  logic [EB-1:0]   rti_src[NA];
  logic [EB-1:0]   rte_src[NA];
  kind_t           rk_src [NA];
  logic            rv_src [NA];
  logic [EB-1:0]   ra_nxt [NA];
  logic [EB-1:0]   rb_nxt [NA];

  always_comb begin
    ra_src[0]  = '0;
    rb_src[0]  = '0;
    rav_src[0] = PADA'(op.operand_a);
    rbv_src[0] = PADA'(op.operand_b);
    rti_src[0] = op.table_index;
    rte_src[0] = op.table_entry;
    rk_src[0]  = kind_t'(op.kind);
    rv_src[0]  = op.valid;
    for (int j = 1; j < NA; j++) begin
      ra_src[j]  = ra_r[j-1];
      rb_src[j]  = rb_r[j-1];
      rav_src[j] = ra_v[j-1];
      rbv_src[j] = rb_v[j-1];
      rti_src[j] = rti[j-1];
      rte_src[j] = rte[j-1];
      rk_src[j]  = rk[j-1];
      rv_src[j]  = rvalid[j-1];
    end
    for (int j = 0; j < NA; j++) begin
      ra_nxt[j] = rem_step(ra_src[j], rav_src[j][PADA-1-j*K -: K], q);
      rb_nxt[j] = rem_step(rb_src[j], rbv_src[j][PADA-1-j*K -: K], q);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int j = 0; j < NA; j++) rvalid[j] <= 1'b0;
    end else if (adv) begin
      for (int j = 0; j < NA; j++) rvalid[j] <= rv_src[j];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int j = 0; j < NA; j++) begin
        ra_r[j] <= ra_nxt[j];
        rb_r[j] <= rb_nxt[j];
        ra_v[j] <= rav_src[j];
        rb_v[j] <= rbv_src[j];
        rti[j]  <= rti_src[j];
        rte[j]  <= rte_src[j];
        rk[j]   <= rk_src[j];
      end
    end
  end

  // --------------------------------------------------------------------------
  // P1: negations, inverses, error detection
  // --------------------------------------------------------------------------
  logic          p1_valid;
  kind_t         p1_kind;
  logic [EB-1:0] p1_a;
  logic [EB-1:0] p1_y;     // right addend (b, or -b for sub)
  logic [EB-1:0] p1_my;    // right factor (b, or 1/b for div)
  logic [EB-1:0] p1_na;
  logic [EB-1:0] p1_inva;
  logic          p1_err;
  logic [EB-1:0] p1_ti;    // Zech address and value of a load
  logic [EB-1:0] p1_te;

  logic [EB-1:0] s1_a, s1_b;
  kind_t         s1_k;
  logic [EB-1:0] s1_y, s1_my;
  logic          s1_err;

  always_comb begin
    s1_a   = ra_r[NA-1];
    s1_b   = rb_r[NA-1];
    s1_k   = rk[NA-1];
    s1_y   = (s1_k == KIND_SUB) ? gf_neg(s1_b, n, half, odd_characteristic) : s1_b;
    s1_my  = (s1_k == KIND_DIV) ? gf_inv(s1_b, q) : s1_b;
    s1_err = (s1_k == KIND_DIV && s1_b == '0) || (s1_k == KIND_INV && s1_a == '0);
  end

  always_ff @(posedge clk) begin
    if (rst) p1_valid <= 1'b0;
    else if (adv) p1_valid <= rvalid[NA-1];
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      p1_kind <= s1_k;
      p1_a    <= s1_a;
      p1_y    <= s1_y;
      p1_my   <= s1_my;
      p1_na   <= gf_neg(s1_a, n, half, odd_characteristic);
      p1_inva <= gf_inv(s1_a, q);
      p1_err  <= s1_err;
      p1_ti   <= rti[NA-1];
      p1_te   <= rte[NA-1];
    end
  end

  // --------------------------------------------------------------------------
  // Zech table: a load writes it as it leaves P1, in item order with the
  // reads, so an add sees only the loads ahead of it; read registered in P2
  // --------------------------------------------------------------------------
  logic [EB-1:0] zech_mem [DEPTH];
  logic [EB-1:0] zaddr;
  logic [EB-1:0] p2_z;

  always_ff @(posedge clk) begin
    if (adv) begin
      if (p1_valid && p1_kind == KIND_LOAD) begin
        zech_mem[p1_ti] <= p1_te;
      end
      p2_z <= zech_mem[zaddr];
    end
  end

  // --------------------------------------------------------------------------
  // P2: product, add special cases, Zech address (table read registered)
  // --------------------------------------------------------------------------
  logic          p2_valid;
  logic          p2_zech;  // result comes from the Zech sum
  logic [EB-1:0] p2_fix;   // result otherwise
  logic          p2_err;
  logic [EB-1:0] p2_lo;

  logic [EB-1:0] s2_ny, s2_hi, s2_lo, s2_fix;
  logic          s2_zech;

  always_comb begin
    s2_ny = gf_neg(p1_y, n, half, odd_characteristic);
    if (p1_a > p1_y) begin
      s2_hi = p1_a;
      s2_lo = p1_y;
    end else begin
      s2_hi = p1_y;
      s2_lo = p1_a;
    end
    zaddr   = s2_hi - s2_lo + EB'(1);
    s2_zech = 1'b0;
    s2_fix  = '0;
    unique case (p1_kind)
      KIND_ADD, KIND_SUB: begin
        // zero operand passes the other through; x + (-x) is zero
        if (p1_y == '0)              s2_fix  = p1_a;
        else if (p1_a == '0)         s2_fix  = p1_y;
        else if (p1_a != s2_ny)      s2_zech = 1'b1;
      end
      KIND_MUL, KIND_DIV: s2_fix = p1_err ? '0 : gf_mul(p1_a, p1_my, n);
      KIND_NEG:           s2_fix = p1_na;
      KIND_INV:           s2_fix = p1_err ? '0 : p1_inva;
      default:            s2_fix = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) p2_valid <= 1'b0;
    else if (adv) p2_valid <= p1_valid;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      p2_zech <= s2_zech;
      p2_fix  <= s2_fix;
      p2_err  <= p1_err;
      p2_lo   <= s2_lo;
    end
  end

  // --------------------------------------------------------------------------
  // Stages S0..S(NS-1): (lo + zech - 1) mod (q-1), K bits per stage
  // --------------------------------------------------------------------------
  logic [EB-1:0]   sr_r   [NS];
  logic [PADS-1:0] sr_v   [NS];
  logic            sz     [NS];
  logic [EB-1:0]   sfix   [NS];
  logic            serr   [NS];
  logic            svalid [NS];

  logic [EB-1:0]   sr_src [NS];
  logic [PADS-1:0] sv_src [NS];
  logic            sz_src [NS];
  logic [EB-1:0]   sf_src [NS];
  logic            se_src [NS];
  logic            svl_src[NS];
  logic [EB-1:0]   sr_nxt [NS];
  logic [EB:0]     zsum;

  always_comb begin
    // lo >= 1 whenever the Zech path is taken, so no underflow there
    zsum       = (EB+1)'(p2_lo) + (EB+1)'(p2_z) - (EB+1)'(1);
    sr_src[0]  = '0;
    sv_src[0]  = PADS'(zsum);
    sz_src[0]  = p2_zech;
    sf_src[0]  = p2_fix;
    se_src[0]  = p2_err;
    svl_src[0] = p2_valid;
    for (int j = 1; j < NS; j++) begin
      sr_src[j]  = sr_r[j-1];
      sv_src[j]  = sr_v[j-1];
      sz_src[j]  = sz[j-1];
      sf_src[j]  = sfix[j-1];
      se_src[j]  = serr[j-1];
      svl_src[j] = svalid[j-1];
    end
    for (int j = 0; j < NS; j++) begin
      sr_nxt[j] = rem_step(sr_src[j], sv_src[j][PADS-1-j*K -: K], {1'b0, n});
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int j = 0; j < NS; j++) svalid[j] <= 1'b0;
    end else if (adv) begin
      for (int j = 0; j < NS; j++) svalid[j] <= svl_src[j];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int j = 0; j < NS; j++) begin
        sr_r[j] <= sr_nxt[j];
        sr_v[j] <= sv_src[j];
        sz[j]   <= sz_src[j];
        sfix[j] <= sf_src[j];
        serr[j] <= se_src[j];
      end
    end
  end

  // --------------------------------------------------------------------------
  // Output register
  // --------------------------------------------------------------------------
  logic          out_valid;
  logic [EB-1:0] out_value;
  logic          out_err;

  always_ff @(posedge clk) begin
    if (rst) out_valid <= 1'b0;
    else if (adv) out_valid <= svalid[NS-1];
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_value <= sz[NS-1] ? (sr_r[NS-1] + EB'(1)) : sfix[NS-1];
      out_err   <= serr[NS-1];
    end
  end

  assign res.valid        = out_valid;
  assign res.result_value = out_value;
  assign res.error_flag   = out_err;

endmodule
